// File: hw/rtl/mcvs_pkg.sv
// ----------------------------------------------------------------------------
// mcvs_pkg: shared types and constants for the min-conflict value scorer
// Field structs for both channels, action codes, default sizes.
// ----------------------------------------------------------------------------
package mcvs_pkg;

  localparam int DEF_MAX_VARS   = 128;
  localparam int DEF_MAX_DOMAIN = 64;
  localparam int DEF_COUNT_BITS = 5;

  localparam logic [6:0] RST_DOMAIN_SIZE = 7'd40;
  localparam logic [7:0] RST_NUM_VARS    = 8'd100;

  localparam logic [0:0] REG_DOMAIN_SIZE = 1'b0;
  localparam logic [0:0] REG_NUM_VARS    = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_SET     = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_FRESH   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  var_index;
    logic [5:0]  value;
    logic [6:0]  other_var;
    logic        make_unset;
    logic [63:0] clash_mask;
  } in_item_t;

  typedef struct packed {
    logic signed [5:0] score;
    logic [4:0]        current_conflicts;
    logic [4:0]        min_conflicts;
    logic [63:0]       best_mask;
    logic [6:0]        best_count;
  } out_item_t;

endpackage

// File: hw/rtl/mcvs_queue.sv
// ----------------------------------------------------------------------------
// mcvs_queue: short queue between front and back
// Two-entry FIFO of input items; full/empty flags only.
// ----------------------------------------------------------------------------
module mcvs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcvs_pkg::in_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output mcvs_pkg::in_item_t pop_data
);
  import mcvs_pkg::*;

  in_item_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hw/rtl/mcvs_back.sv
// ----------------------------------------------------------------------------
// mcvs_back: execution engine
// Applies loads and sets, walks the variables for queries one table read a
// cycle, then finds minimum and best mask and presents the result.
// ----------------------------------------------------------------------------
module mcvs_back #(
  parameter int MAX_VARS   = mcvs_pkg::DEF_MAX_VARS,
  parameter int MAX_DOMAIN = mcvs_pkg::DEF_MAX_DOMAIN,
  parameter int COUNT_BITS = mcvs_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [6:0]          domain_size,
  input  logic [7:0]          num_vars,
  input  logic                q_empty,
  input  mcvs_pkg::in_item_t  q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mcvs_pkg::out_item_t out_data
);
  import mcvs_pkg::*;

  localparam int VB = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int DB = (MAX_DOMAIN > 1) ? $clog2(MAX_DOMAIN) : 1;
  localparam int AB = 2 * VB + DB;
  localparam int CNTW = VB + 1;
  localparam int DOMW = DB + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_CUR, S_MIN, S_OUT} state_t;

  logic [63:0] table_mem [2**AB];
  logic [DB-1:0] asg_val   [MAX_VARS];
  logic [MAX_VARS-1:0] asg_ok;

  state_t state;
  in_item_t item;
  logic [CNTW-1:0] c_idx;
  logic [CNTW-1:0] nv;
  logic [DOMW-1:0] dom;
  logic [COUNT_BITS-1:0] counts [MAX_DOMAIN];
  logic [63:0] rd_mask;
  logic        rd_live;
  logic        a_live;
  logic [VB-1:0] c_pipe;
  logic [DB-1:0] asg_rd;
  logic [DB-1:0] cur_val;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] minc;
  logic        q_ok;

  logic [VB-1:0] u;
  logic [VB-1:0] c;
  logic [AB-1:0] rd_addr;
  logic        c_take;
  logic [COUNT_BITS-1:0] min_comb;
  logic [MAX_DOMAIN-1:0] cand;
  logic [MAX_DOMAIN-1:0] zero_b;
  logic [63:0] bmask_comb;
  logic [6:0]  bcount_comb;

  assign u  = item.var_index[VB-1:0];
  assign c  = c_idx[VB-1:0];
  // stage two of the walk: assignment of c was read the cycle before
  assign rd_addr = {c_pipe, asg_rd, u};
  assign c_take = (c != u) && asg_ok[c];
  assign q_ok  = (32'(item.var_index) < MAX_VARS);
  assign q_pop = (state == S_IDLE) && !q_empty;

  // minimum, MSB first: keep the values whose bit is zero if any has one
  always_comb begin
    cand = '0;
    for (int k = 0; k < MAX_DOMAIN; k++) cand[k] = (k < 32'(dom));
    min_comb = CMAX;
    for (int b = COUNT_BITS - 1; b >= 0; b--) begin
      zero_b = '0;
      for (int k = 0; k < MAX_DOMAIN; k++) zero_b[k] = cand[k] && !counts[k][b];
      if (|zero_b) begin
        min_comb[b] = 1'b0;
        cand        = zero_b;
      end
    end
  end

  always_comb begin
    bmask_comb = '0;
    for (int k = 0; k < MAX_DOMAIN; k++) begin
      if (k < 32'(dom) && counts[k] == minc) bmask_comb[k] = 1'b1;
    end
  end

  assign bcount_comb = 7'($countones(bmask_comb));

  // table write and registered read
  always_ff @(posedge clk) begin
    if (q_pop && q_data.action == ACT_LOAD &&
        32'(q_data.var_index) < MAX_VARS && 32'(q_data.other_var) < MAX_VARS &&
        32'(q_data.value) < MAX_DOMAIN) begin
      table_mem[{q_data.var_index[VB-1:0], q_data.value[DB-1:0],
                 q_data.other_var[VB-1:0]}] <= q_data.clash_mask;
    end
    rd_mask <= table_mem[rd_addr];
  end

  // assignment values: written on set, two registered read ports
  always_ff @(posedge clk) begin
    if (q_pop && q_data.action == ACT_SET && 32'(q_data.var_index) < MAX_VARS) begin
      asg_val[q_data.var_index[VB-1:0]] <= q_data.value[DB-1:0];
    end
    asg_rd  <= asg_val[c];
    cur_val <= asg_val[u];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      asg_ok    <= '0;
      out_valid <= 1'b0;
      rd_live   <= 1'b0;
      a_live    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            item <= q_data;
            unique case (action_t'(q_data.action))
              ACT_LOAD: ;
              ACT_SET: begin
                if (32'(q_data.var_index) < MAX_VARS && 32'(q_data.value) < MAX_DOMAIN)
                  asg_ok[q_data.var_index[VB-1:0]] <= !q_data.make_unset;
                else if (32'(q_data.var_index) < MAX_VARS)
                  asg_ok[q_data.var_index[VB-1:0]] <= 1'b0;
              end
              ACT_REPLACE, ACT_FRESH: begin
                c_idx <= '0;
                nv  <= (32'(num_vars) < MAX_VARS) ? CNTW'(num_vars) : CNTW'(MAX_VARS);
                dom <= (32'(domain_size) < MAX_DOMAIN) ? DOMW'(domain_size)
                                                       : DOMW'(MAX_DOMAIN);
                for (int k = 0; k < MAX_DOMAIN; k++) counts[k] <= '0;
                state <= S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          a_live  <= q_ok && (c_idx < nv) && c_take;
          c_pipe  <= c;
          rd_live <= a_live;
          if (!q_ok || c_idx >= nv) state <= S_DRAIN;
          else c_idx <= c_idx + CNTW'(1);
          if (rd_live) begin
            for (int k = 0; k < MAX_DOMAIN; k++)
              if (rd_mask[k] && counts[k] != CMAX) counts[k] <= counts[k] + COUNT_BITS'(1);
          end
        end
        S_DRAIN: begin
          a_live  <= 1'b0;
          rd_live <= a_live;
          if (rd_live) begin
            for (int k = 0; k < MAX_DOMAIN; k++)
              if (rd_mask[k] && counts[k] != CMAX) counts[k] <= counts[k] + COUNT_BITS'(1);
          end
          if (!a_live) state <= S_CUR;
        end
        S_CUR: begin
          cur <= '0;
          if (item.action == ACT_REPLACE && q_ok && asg_ok[u]) begin
            cur <= counts[cur_val];
            counts[cur_val] <= CMAX;
          end
          state <= S_MIN;
        end
        S_MIN: begin
          minc  <= min_comb;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_data.score             <= 6'(cur) - 6'(minc);
            out_data.current_conflicts <= 5'(cur);
            out_data.min_conflicts     <= 5'(minc);
            out_data.best_mask         <= bmask_comb;
            out_data.best_count        <= bcount_comb;
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/mcvs_front.sv
// ----------------------------------------------------------------------------
// mcvs_front: input stage
// Takes input transfers into the queue and holds the config registers.
// ----------------------------------------------------------------------------
module mcvs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcvs_pkg::in_item_t in_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic [6:0]         domain_size,
  output logic [7:0]         num_vars,
  input  logic               q_full,
  output logic               q_push,
  output mcvs_pkg::in_item_t q_data
);
  import mcvs_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_size <= RST_DOMAIN_SIZE;
      num_vars    <= RST_NUM_VARS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOMAIN_SIZE: domain_size <= cfg_data[6:0];
        REG_NUM_VARS:    num_vars    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/min_conflict_value_scorer.sv
// ----------------------------------------------------------------------------
// min_conflict_value_scorer: min-conflicts value selection scorer
// Conflict table, assignment store and query engine for local search.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid / in_stall  | in_data  (in_item_t)
// out      | out_valid / out_stall| out_data (out_item_t)
// cfg      | cfg_we               | cfg_index, cfg_data
//
// Load and set are applied in the back part as they are popped; a query walks
// num_vars variables (num_vars capped at MAX_VARS) with one table read per
// variable behind an assignment read stage, then finds minimum and best mask.
// Reset clears assignments, resets config; the table is undefined until loaded.
// in_stall rises when the 2-entry queue is full; out_stall holds the result.
module min_conflict_value_scorer #(
  parameter int MAX_VARS   = mcvs_pkg::DEF_MAX_VARS,
  parameter int MAX_DOMAIN = mcvs_pkg::DEF_MAX_DOMAIN,
  parameter int COUNT_BITS = mcvs_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcvs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcvs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import mcvs_pkg::*;

  logic [6:0] domain_size;
  logic [7:0] num_vars;
  logic       q_full, q_empty, q_push, q_pop;
  in_item_t   q_in, q_out;

  // front: accepts transfers, holds config
  mcvs_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .cfg_we, .cfg_index, .cfg_data, .domain_size, .num_vars,
    .q_full, .q_push, .q_data(q_in)
  );

  mcvs_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out)
  );

  // back: executes items one at a time
  mcvs_back #(
    .MAX_VARS(MAX_VARS), .MAX_DOMAIN(MAX_DOMAIN), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk, .rst, .domain_size, .num_vars,
    .q_empty, .q_data(q_out), .q_pop,
    .out_valid, .out_stall, .out_data
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("push into full queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_best_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.best_mask == '0) == (out_data.best_count == '0)))
    else $error("best mask and count disagree");

endmodule
